/* rtl/core/ifx_pkg.sv */
// Shared types, character codes and constants for the infix four-operator evaluator.
package ifx_pkg;

    localparam int VALUE_WIDTH_DEF = 32;
    localparam int CHAR_WIDTH      = 8;
    localparam int VAL_OUT_WIDTH   = 32;
    localparam int STATUS_WIDTH    = 2;
    localparam int M_TDATA_WIDTH   = 40;
    localparam int M_PAD_WIDTH     = M_TDATA_WIDTH - VAL_OUT_WIDTH - STATUS_WIDTH;

    localparam logic [CHAR_WIDTH-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_WIDTH-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_WIDTH-1:0] CH_STAR  = 8'h2A;
    localparam logic [CHAR_WIDTH-1:0] CH_SLASH = 8'h2F;
    localparam logic [CHAR_WIDTH-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_WIDTH-1:0] CH_NINE  = 8'h39;

    localparam int DECIMAL_BASE = 10;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } op_t;

    typedef enum logic [STATUS_WIDTH-1:0] {
        ST_OK    = 2'd0,
        ST_DIV0  = 2'd1,
        ST_OVFL  = 2'd2,
        ST_RSVD  = 2'd3
    } status_t;

    // error flag bit positions
    localparam int ERR_DIV0 = 0;
    localparam int ERR_OVFL = 1;

    // request from the sequencer to the shared multiply/divide unit
    typedef struct packed {
        logic start;
        logic is_div;
    } ifx_req_t;

endpackage

/* rtl/core/ifx_muldiv.sv */
// Iterative multiply / signed divide unit built around one shared adder.
module ifx_muldiv #(
    parameter int WIDTH = ifx_pkg::VALUE_WIDTH_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  ifx_pkg::ifx_req_t req,
    input  logic [WIDTH-1:0] a,
    input  logic [WIDTH-1:0] b,
    output logic             done,
    output logic [WIDTH-1:0] result
);
    import ifx_pkg::*;

    localparam int CW = $clog2(WIDTH);
    localparam logic [CW-1:0] CNT_LAST = CW'(WIDTH - 1);

    typedef enum logic [2:0] {
        U_IDLE = 3'b001,
        U_RUN  = 3'b010,
        U_FIX  = 3'b100
    } ustate_t;

    ustate_t          state_reg, state_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic [WIDTH-1:0] acc_reg, acc_next;
    logic [WIDTH-1:0] x_reg, x_next;
    logic [WIDTH-1:0] y_reg, y_next;
    logic             div_reg, div_next;
    logic             neg_reg, neg_next;
    logic             done_reg, done_next;
    logic [WIDTH-1:0] res_reg, res_next;

    logic [WIDTH:0]   op_a, op_b;
    logic             sub;
    logic [WIDTH+1:0] sum;
    logic             no_borrow;
    logic [WIDTH-1:0] abs_a, abs_b;

    // the one shared adder: A + B, or A - B with carry out meaning A >= B
    assign sum = {1'b0, op_a} + {1'b0, (sub ? ~op_b : op_b)} + (WIDTH+2)'(sub);
    assign no_borrow = sum[WIDTH+1];

    assign abs_a = (a ^ {WIDTH{a[WIDTH-1]}}) + WIDTH'(a[WIDTH-1]);
    assign abs_b = (b ^ {WIDTH{b[WIDTH-1]}}) + WIDTH'(b[WIDTH-1]);

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        acc_next   = acc_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        div_next   = div_reg;
        neg_next   = neg_reg;
        res_next   = res_reg;
        done_next  = 1'b0;
        op_a       = '0;
        op_b       = '0;
        sub        = 1'b0;
        case (state_reg)
            U_IDLE:
            begin
                if (req.start)
                begin
                    div_next   = req.is_div;
                    acc_next   = '0;
                    cnt_next   = '0;
                    neg_next   = a[WIDTH-1] ^ b[WIDTH-1];
                    x_next     = req.is_div ? abs_a : a;
                    y_next     = req.is_div ? abs_b : b;
                    state_next = U_RUN;
                end
            end
            U_RUN:
            begin
                if (div_reg)
                begin
                    // restoring step: shift in next dividend bit, try subtract
                    op_a     = {acc_reg, x_reg[WIDTH-1]};
                    op_b     = {1'b0, y_reg};
                    sub      = 1'b1;
                    acc_next = no_borrow ? sum[WIDTH-1:0] : op_a[WIDTH-1:0];
                    x_next   = {x_reg[WIDTH-2:0], no_borrow};
                end
                else
                begin
                    // shift-add step, product kept modulo 2^WIDTH
                    op_a     = {1'b0, acc_reg};
                    op_b     = y_reg[0] ? {1'b0, x_reg} : '0;
                    acc_next = sum[WIDTH-1:0];
                    x_next   = {x_reg[WIDTH-2:0], 1'b0};
                    y_next   = {1'b0, y_reg[WIDTH-1:1]};
                end
                cnt_next = cnt_reg + CW'(1);
                if (cnt_reg == CNT_LAST)
                begin
                    state_next = U_FIX;
                end
            end
            U_FIX:
            begin
                // negate the quotient when the operand signs differ
                op_b       = {1'b0, x_reg};
                sub        = 1'b1;
                res_next   = div_reg ? (neg_reg ? sum[WIDTH-1:0] : x_reg) : acc_reg;
                done_next  = 1'b1;
                state_next = U_IDLE;
            end
            default:
            begin
                state_next = U_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= U_IDLE;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
            div_reg   <= 1'b0;
            neg_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            cnt_reg   <= cnt_next;
            div_reg   <= div_next;
            neg_reg   <= neg_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        x_reg   <= x_next;
        y_reg   <= y_next;
        res_reg <= res_next;
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule

/* rtl/core/infix_four_op_evaluator.sv */
// Top level of the character-serial infix four-operator expression evaluator.
//
//  channel | direction | tdata (low bit up)                  | tuser | tlast
//  --------+-----------+-------------------------------------+-------+------------
//  s_*     | in        | char_code[7:0]                      | -     | end_of_expr
//  m_*     | out       | value[31:0], status[33:32], 0 pad   | -     | -
//
//  Digit and ignored characters are accepted (S_IDLE), then decoded (S_DECODE).
//  '+' / '-', and '/' by zero, are then applied in S_APPLY; '*' and '/' also wait in
//  S_WAIT on the bit-serial multiply/divide unit.
//  A last word adds one more apply pass plus a sum step (S_SUM) before the result shows.
//  Reset (rst_n low, asynchronous) clears all expression state; no clearing pass.
//  s_tready is low while a word is in work and while the result waits on m_tready.
module infix_four_op_evaluator #(
    parameter int VALUE_WIDTH = ifx_pkg::VALUE_WIDTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [ifx_pkg::CHAR_WIDTH-1:0]      s_tdata,   // [7:0] char_code
    input  logic                                s_tlast,   // end_of_expr
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [ifx_pkg::M_TDATA_WIDTH-1:0]   m_tdata    // [31:0] value, [33:32] status
);
    import ifx_pkg::*;

    localparam int W = VALUE_WIDTH;
    // largest number a digit run may build
    localparam logic [W+3:0] NMAX_X = (W+4)'({(W-1){1'b1}});
    localparam logic [W-1:0] NMAX   = W'({(W-1){1'b1}});

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_DECODE = 6'b000010,
        S_APPLY  = 6'b000100,
        S_WAIT   = 6'b001000,
        S_SUM    = 6'b010000,
        S_OUT    = 6'b100000
    } state_t;

    state_t                 state_reg, state_next;
    logic [CHAR_WIDTH-1:0]  chr_reg;
    logic                   last_reg, last_next;
    logic                   fin_reg, fin_next;
    op_t                    nop_reg, nop_next;
    op_t                    pend_reg, pend_next;
    logic [W-1:0]           accum_reg, accum_next;
    logic [W-1:0]           sum_reg, sum_next;
    logic [W-1:0]           term_reg, term_next;
    logic [1:0]             flags_reg, flags_next;
    logic [VAL_OUT_WIDTH-1:0] value_reg, value_next;
    status_t                status_reg, status_next;

    ifx_req_t               md_req;
    logic                   md_done;
    logic [W-1:0]           md_result;

    logic                   is_digit;
    logic [3:0]             digit;
    logic [W+3:0]           times10;
    logic                   apply_done;
    logic signed [W-1:0]    total;

    assign is_digit = chr_reg inside {[CH_ZERO:CH_NINE]};
    assign digit    = 4'(chr_reg - CH_ZERO);
    // accum * 10 + d, wide enough that the compare against the max is exact
    assign times10  = {1'b0, accum_reg, 3'b000} + {3'b000, accum_reg, 1'b0}
                      + (W+4)'(digit);
    assign total    = signed'(sum_reg + term_reg);

    always_comb
    begin
        md_req.start  = (state_reg == S_APPLY)
                        && ((pend_reg == OP_MUL)
                            || ((pend_reg == OP_DIV) && (accum_reg != '0)));
        md_req.is_div = (pend_reg == OP_DIV);
    end

    ifx_muldiv #(
        .WIDTH (W)
    ) u_muldiv (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (md_req),
        .a      (term_reg),
        .b      (accum_reg),
        .done   (md_done),
        .result (md_result)
    );

    always_comb
    begin
        state_next  = state_reg;
        last_next   = last_reg;
        fin_next    = fin_reg;
        nop_next    = nop_reg;
        pend_next   = pend_reg;
        accum_next  = accum_reg;
        sum_next    = sum_reg;
        term_next   = term_reg;
        flags_next  = flags_reg;
        value_next  = value_reg;
        status_next = status_reg;
        apply_done  = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    last_next  = s_tlast;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                // on the last word the final pass folds the number as by '+'
                fin_next   = last_reg;
                nop_next   = OP_ADD;
                state_next = last_reg ? S_APPLY : S_IDLE;
                if (is_digit)
                begin
                    if (times10 > NMAX_X)
                    begin
                        accum_next           = NMAX;
                        flags_next[ERR_OVFL] = 1'b1;
                    end
                    else
                    begin
                        accum_next = times10[W-1:0];
                    end
                end
                else
                begin
                    case (chr_reg)
                        CH_PLUS:
                        begin
                            fin_next   = 1'b0;
                            nop_next   = OP_ADD;
                            state_next = S_APPLY;
                        end
                        CH_MINUS:
                        begin
                            fin_next   = 1'b0;
                            nop_next   = OP_SUB;
                            state_next = S_APPLY;
                        end
                        CH_STAR:
                        begin
                            fin_next   = 1'b0;
                            nop_next   = OP_MUL;
                            state_next = S_APPLY;
                        end
                        CH_SLASH:
                        begin
                            fin_next   = 1'b0;
                            nop_next   = OP_DIV;
                            state_next = S_APPLY;
                        end
                        default:
                        begin
                            // ignored character: state untouched
                        end
                    endcase
                end
            end
            S_APPLY:
            begin
                case (pend_reg)
                    OP_ADD:
                    begin
                        sum_next   = sum_reg + term_reg;
                        term_next  = accum_reg;
                        apply_done = 1'b1;
                    end
                    OP_SUB:
                    begin
                        sum_next   = sum_reg + term_reg;
                        term_next  = W'(0) - accum_reg;
                        apply_done = 1'b1;
                    end
                    OP_MUL:
                    begin
                        state_next = S_WAIT;
                    end
                    OP_DIV:
                    begin
                        if (accum_reg == '0)
                        begin
                            term_next            = '0;
                            flags_next[ERR_DIV0] = 1'b1;
                            apply_done           = 1'b1;
                        end
                        else
                        begin
                            state_next = S_WAIT;
                        end
                    end
                    default:
                    begin
                        apply_done = 1'b1;
                    end
                endcase
            end
            S_WAIT:
            begin
                if (md_done)
                begin
                    term_next  = md_result;
                    apply_done = 1'b1;
                end
            end
            S_SUM:
            begin
                // sign-extend or truncate to the output width, then clear
                value_next  = VAL_OUT_WIDTH'(total);
                status_next = flags_reg[ERR_DIV0] ? ST_DIV0
                            : (flags_reg[ERR_OVFL] ? ST_OVFL : ST_OK);
                accum_next  = '0;
                pend_next   = OP_ADD;
                sum_next    = '0;
                term_next   = '0;
                flags_next  = '0;
                fin_next    = 1'b0;
                last_next   = 1'b0;
                state_next  = S_OUT;
            end
            S_OUT:
            begin
                if (m_tready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // common tail of every operator application
        if (apply_done)
        begin
            pend_next  = nop_reg;
            accum_next = '0;
            if (fin_reg)
            begin
                state_next = S_SUM;
            end
            else if (last_reg)
            begin
                fin_next   = 1'b1;
                nop_next   = OP_ADD;
                state_next = S_APPLY;
            end
            else
            begin
                state_next = S_IDLE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            last_reg  <= 1'b0;
            fin_reg   <= 1'b0;
            nop_reg   <= OP_ADD;
            pend_reg  <= OP_ADD;
            accum_reg <= '0;
            sum_reg   <= '0;
            term_reg  <= '0;
            flags_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            last_reg  <= last_next;
            fin_reg   <= fin_next;
            nop_reg   <= nop_next;
            pend_reg  <= pend_next;
            accum_reg <= accum_next;
            sum_reg   <= sum_next;
            term_reg  <= term_next;
            flags_reg <= flags_next;
        end
    end

    // payload registers: capture the character, hold the result word
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE)
        begin
            chr_reg <= s_tdata;
        end
        value_reg  <= value_next;
        status_reg <= status_next;
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = (state_reg == S_OUT);
    assign m_tdata  = {{M_PAD_WIDTH{1'b0}}, status_reg, value_reg};

endmodule

/* test/tb_infix_four_op_evaluator.sv */
// Testbench for infix_four_op_evaluator: character stream in, expression value and status out.
module tb_infix_four_op_evaluator;

    timeunit 1ns;
    timeprecision 1ps;

    import ifx_pkg::*;

    localparam int          HALF_PERIOD   = 2;
    localparam int          RESET_CYCLES  = 7;
    localparam int          TARGET_WORDS  = 1200;
    localparam int          MAX_GAP       = 18;
    // receiver hold-off long enough to back the block up into its input
    localparam int          HOLD_CYCLES   = 400;
    localparam int          HOLD_AT_WORD  = 300;
    localparam int          DRAIN_AT_WORD = 700;
    // worst word is a divide plus the final apply pass, well under this
    localparam int          TAIL_CYCLES   = 120;
    localparam int          IDLE_LIMIT    = 4000;
    localparam int          MAX_REPORTS   = 10;
    localparam logic [31:0] NUM_MAX       = 32'h7FFF_FFFF;
    localparam logic [7:0]  CH_SPACE      = 8'h20;

    typedef struct {
        logic [31:0] value;
        status_t     status;
    } expr_value_t;

    // Tracks the evaluator state word by word and checks each output word.
    class expr_scoreboard;
        expr_value_t expr_values_q[$];
        logic [31:0] number_accum;
        op_t         pending_op;
        logic [31:0] running_sum;
        logic [31:0] last_term;
        logic [1:0]  err_flags;
        int          fail_count;
        int          words_in;
        int          exprs_checked;
        int          div0_exprs;
        int          ovfl_exprs;

        function new();
            clear_expr();
        endfunction

        function void clear_expr();
            number_accum = '0;
            pending_op   = OP_ADD;
            running_sum  = '0;
            last_term    = '0;
            err_flags    = '0;
        endfunction

        // signed divide, truncating toward zero, safe for the most negative value
        function logic [31:0] div_trunc(logic [31:0] num, logic [31:0] den);
            logic [31:0] mag_n;
            logic [31:0] mag_d;
            logic [31:0] quo;
            mag_n = num[31] ? -num : num;
            mag_d = den[31] ? -den : den;
            quo   = mag_n / mag_d;
            return (num[31] ^ den[31]) ? -quo : quo;
        endfunction

        // apply the pending operator to the number, then make next_op pending
        function void fold_number(op_t next_op);
            case (pending_op)
                OP_ADD:
                begin
                    running_sum = running_sum + last_term;
                    last_term   = number_accum;
                end
                OP_SUB:
                begin
                    running_sum = running_sum + last_term;
                    last_term   = -number_accum;
                end
                OP_MUL:
                begin
                    last_term = last_term * number_accum;
                end
                default:
                begin
                    if (number_accum == '0)
                    begin
                        last_term           = '0;
                        err_flags[ERR_DIV0] = 1'b1;
                    end
                    else
                    begin
                        last_term = div_trunc(last_term, number_accum);
                    end
                end
            endcase
            pending_op   = next_op;
            number_accum = '0;
        endfunction

        function void note_word(logic [7:0] ch, logic last);
            logic [31:0] digit;
            expr_value_t exp_val;
            words_in++;
            if (ch >= CH_ZERO && ch <= CH_NINE)
            begin
                digit = 32'(ch - CH_ZERO);
                if (number_accum > (NUM_MAX - digit) / DECIMAL_BASE)
                begin
                    number_accum        = NUM_MAX;
                    err_flags[ERR_OVFL] = 1'b1;
                end
                else
                begin
                    number_accum = number_accum * DECIMAL_BASE + digit;
                end
            end
            else
            begin
                case (ch)
                    CH_PLUS:  fold_number(OP_ADD);
                    CH_MINUS: fold_number(OP_SUB);
                    CH_STAR:  fold_number(OP_MUL);
                    CH_SLASH: fold_number(OP_DIV);
                    default:  ;
                endcase
            end
            if (!last)
                return;
            // end of expression: fold as if a '+' followed
            fold_number(OP_ADD);
            exp_val.value = running_sum + last_term;
            if (err_flags[ERR_DIV0])
                exp_val.status = ST_DIV0;
            else if (err_flags[ERR_OVFL])
                exp_val.status = ST_OVFL;
            else
                exp_val.status = ST_OK;
            if (err_flags[ERR_DIV0])
                div0_exprs++;
            if (err_flags[ERR_OVFL])
                ovfl_exprs++;
            expr_values_q.push_back(exp_val);
            clear_expr();
        endfunction

        function void check_word(logic [M_TDATA_WIDTH-1:0] data);
            expr_value_t exp_val;
            logic [M_PAD_WIDTH-1:0] pad;
            pad = data[M_TDATA_WIDTH-1 -: M_PAD_WIDTH];
            if (expr_values_q.size() == 0)
            begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                    $display("%0t: output word %h with no expression pending", $realtime, data);
                return;
            end
            exp_val = expr_values_q.pop_front();
            exprs_checked++;
            if (data[31:0] !== exp_val.value || data[33:32] !== exp_val.status || pad !== '0)
            begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                    $display({"%0t: expr %0d: expected value %0d status %0d, ",
                              "got value %0d status %0d pad %h"},
                             $realtime, exprs_checked, $signed(exp_val.value),
                             exp_val.status, $signed(data[31:0]), data[33:32], pad);
            end
        endfunction

        function int pending();
            return expr_values_q.size();
        endfunction
    endclass

    logic                       clk;
    logic                       rst_n;
    logic                       s_tvalid;
    logic                       s_tready;
    logic [CHAR_WIDTH-1:0]      s_tdata;
    logic                       s_tlast;
    logic                       m_tvalid;
    logic                       m_tready;
    logic [M_TDATA_WIDTH-1:0]   m_tdata;

    expr_scoreboard sb = new();
    logic [7:0]     expr_chars[$];
    bit             hold_req;
    int             idle_cycles;
    int             counted_words;

    infix_four_op_evaluator u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #HALF_PERIOD clk = ~clk;

    // Watchdog: count cycles in which neither side moves a word.
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("%0t: watchdog, no word moved for %0d cycles", $realtime, IDLE_LIMIT);
                $display("tb_infix_four_op_evaluator NOT OK");
                $finish;
            end
        end
    end

    // Offer one word after an idle gap; hold it until accepted.
    task automatic send_word(input logic [7:0] ch, input logic last, input int gap);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= ch;
        s_tlast  <= last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.note_word(ch, last);
        if (last || (ch >= CH_ZERO && ch <= CH_NINE) || ch == CH_PLUS || ch == CH_MINUS ||
            ch == CH_STAR || ch == CH_SLASH)
            counted_words++;
    endtask

    task automatic send_text(input string text);
        for (int i = 0; i < text.len(); i++)
            send_word(text[i], i == text.len() - 1, $urandom_range(0, MAX_GAP));
    endtask

    task automatic push_number(input bit allow_zero);
        int sel;
        int n_digits;
        sel = $urandom_range(0, 19);
        if (allow_zero)
        begin
            expr_chars.push_back(CH_ZERO);
            return;
        end
        if (sel < 12)
            n_digits = 1;
        else if (sel < 16)
            n_digits = $urandom_range(2, 3);
        else if (sel < 18)
            n_digits = $urandom_range(4, 6);
        else
            n_digits = $urandom_range(9, 12);
        repeat (n_digits)
            expr_chars.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
    endtask

    function automatic logic [7:0] pick_op();
        case ($urandom_range(0, 3))
            0:       return CH_PLUS;
            1:       return CH_MINUS;
            2:       return CH_STAR;
            default: return CH_SLASH;
        endcase
    endfunction

    // Build one expression: mostly well-formed number/operator chains with
    // spaces and noise, sometimes leading, doubled or trailing operators,
    // sometimes pure junk.
    task automatic build_expr();
        int         n_terms;
        logic [7:0] op;
        expr_chars.delete();
        if ($urandom_range(0, 11) == 0)
        begin
            repeat ($urandom_range(1, 6))
                expr_chars.push_back(8'($urandom_range(0, 255)));
            return;
        end
        n_terms = $urandom_range(1, 6);
        op      = CH_PLUS;
        if ($urandom_range(0, 7) == 0)
        begin
            op = pick_op();
            expr_chars.push_back(op);
        end
        for (int t = 0; t < n_terms; t++)
        begin
            if (t > 0)
            begin
                op = pick_op();
                expr_chars.push_back(op);
                if ($urandom_range(0, 14) == 0)
                    expr_chars.push_back(pick_op());
            end
            if ($urandom_range(0, 4) == 0)
                expr_chars.push_back(CH_SPACE);
            push_number(op == CH_SLASH && $urandom_range(0, 5) == 0);
            if ($urandom_range(0, 19) == 0)
                expr_chars.push_back(8'($urandom_range(0, 255)));
        end
        case ($urandom_range(0, 9))
            0:       expr_chars.push_back(pick_op());
            1:       expr_chars.push_back(CH_SPACE);
            default: ;
        endcase
    endtask

    // Sender: reset, directed expressions, then random ones.
    initial
    begin
        bit burst;
        bit drained;
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tlast  <= 1'b0;
        m_tready <= 1'b0;
        hold_req = 1'b0;
        drained  = 1'b0;
        counted_words = 0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // extremes of the character field; junk only, value stays zero
        send_word(8'h00, 1'b0, 0);
        send_word(8'hFF, 1'b1, 0);
        // negative dividend truncates toward zero
        send_text("-7/2");
        // divide by zero, then more terms
        send_text("6/0+1");
        // number saturates at the maximum
        send_text("9999999999");
        // bare operators, missing numbers count as zero
        send_text("*+");

        while (counted_words < TARGET_WORDS)
        begin
            build_expr();
            burst = ($urandom_range(0, 3) == 0);
            foreach (expr_chars[i])
                send_word(expr_chars[i], i == expr_chars.size() - 1,
                          burst ? 0 : $urandom_range(0, MAX_GAP));
            if (counted_words >= HOLD_AT_WORD && counted_words < DRAIN_AT_WORD)
                hold_req = 1'b1;
            if (!drained && counted_words >= DRAIN_AT_WORD)
            begin
                // pause until every pending expression has come out
                s_tvalid <= 1'b0;
                while (sb.pending() > 0)
                    @(posedge clk);
                drained = 1'b1;
            end
        end
        s_tvalid <= 1'b0;
        s_tlast  <= 1'b0;

        while (sb.pending() > 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Ran %0d words through %0d expressions", sb.words_in, sb.exprs_checked);
        $display("(%0d with divide by zero, %0d with number overflow), %0d mismatches.",
                 sb.div0_exprs, sb.ovfl_exprs, sb.fail_count);
        if (sb.fail_count == 0)
            $display("tb_infix_four_op_evaluator OK");
        else
            $display("tb_infix_four_op_evaluator NOT OK");
        $finish;
    end

    // Receiver: random ready gaps with burst stretches, one long hold-off.
    initial
    begin
        int  gap;
        int  mode_left;
        bit  burst;
        bit  held;
        held      = 1'b0;
        mode_left = 0;
        burst     = 1'b0;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            if (mode_left == 0)
            begin
                burst     = ($urandom_range(0, 2) == 0);
                mode_left = $urandom_range(4, 12);
            end
            mode_left--;
            gap = burst ? 0 : $urandom_range(0, MAX_GAP);
            if (hold_req && !held)
            begin
                // block backs up while the sender keeps offering
                gap  = HOLD_CYCLES;
                held = 1'b1;
            end
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid)
                @(posedge clk);
            sb.check_word(m_tdata);
        end
    end

endmodule
